[sv/abmio_pkg.sv]
// Shared types, codes and constants of the arcade board memory and I/O block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package abmio_pkg;

    localparam int MEM_ADDR_W = 14;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 16;
    localparam int PORT_W     = 8;
    localparam int BUTTON_W   = 3;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [2:0] {
        OP_MEM_READ  = 3'd0,
        OP_MEM_WRITE = 3'd1,
        OP_IO_IN     = 3'd2,
        OP_IO_OUT    = 3'd3,
        OP_BUTTON    = 3'd4,
        OP_ROM_LOAD  = 3'd5
    } op_t;

    localparam logic [PORT_W-1:0] PORT_SWITCHES0    = 8'd0;
    localparam logic [PORT_W-1:0] PORT_BUTTONS      = 8'd1;
    localparam logic [PORT_W-1:0] PORT_SWITCHES2    = 8'd2;
    localparam logic [PORT_W-1:0] PORT_SHIFT_READ   = 8'd3;
    localparam logic [PORT_W-1:0] PORT_SHIFT_AMOUNT = 8'd2;
    localparam logic [PORT_W-1:0] PORT_SHIFT_DATA   = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT0_SWITCHES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT2_SWITCHES = 1'b1;

    localparam logic [BUTTON_W-1:0] BTN_COIN       = 3'd0;
    localparam logic [BUTTON_W-1:0] BTN_TWO_PLAYER = 3'd1;
    localparam logic [BUTTON_W-1:0] BTN_ONE_PLAYER = 3'd2;
    localparam logic [BUTTON_W-1:0] BTN_FIRE       = 3'd3;
    localparam logic [BUTTON_W-1:0] BTN_LEFT       = 3'd4;
    localparam logic [BUTTON_W-1:0] BTN_RIGHT      = 3'd5;

    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   address;
        logic [PORT_W-1:0]   port;
        logic [BYTE_W-1:0]   data;
        logic [BUTTON_W-1:0] button;
        logic                pressed;
    } item_t;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [MEM_ADDR_W-1:0] rd_addr;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0]     wr_data;
    } mem_req_t;

    function automatic logic [BYTE_W-1:0] button_mask(input logic [BUTTON_W-1:0] btn);
        logic [BYTE_W-1:0] mask;
        case (btn)
            BTN_COIN:       mask = 8'h01;
            BTN_TWO_PLAYER: mask = 8'h02;
            BTN_ONE_PLAYER: mask = 8'h04;
            BTN_FIRE:       mask = 8'h10;
            BTN_LEFT:       mask = 8'h20;
            BTN_RIGHT:      mask = 8'h40;
            default:        mask = 8'h00;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

[sv/arcade_board_memory_and_io.sv]
// Top level of the arcade board memory and I/O block: address decode,
// result selection and the result register. Depends on abmio_pkg, abmio_mem, abmio_io.
//
// Usage:
//   Command channel: an item (op, address, port, data, button, pressed) is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with read_data; the receiver
//   cannot stall it. Every item gives exactly one result, zero unless the
//   item is a memory read or an I/O input.
//   Result path: an accepted item sets s1_valid_reg, which then sets done_reg.
//   Throughput: one item per cycle while busy is low; each item
//   makes at most one store read or one store write, at the accepting edge.
//   Configuration: cfg_write with cfg_index 0 writes port0_switches, index 1
//   writes port2_switches; taken at any edge, including while busy.
//   Reset: all control state, switches, shift pair and button latch clear at
//   once; the store's 16384 bytes are then zeroed one byte a cycle, with busy
//   high throughout. busy never rises again after that sweep.
`default_nettype none

module arcade_board_memory_and_io (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      op,
    input  wire logic [abmio_pkg::ADDR_W-1:0]    address,
    input  wire logic [abmio_pkg::PORT_W-1:0]    port,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    data,
    input  wire logic [abmio_pkg::BUTTON_W-1:0]  button,
    input  wire logic                            pressed,
    output logic [abmio_pkg::BYTE_W-1:0]         read_data,
    output logic                                 done,
    input  wire logic                            cfg_write,
    input  wire logic [abmio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_IO
    } src_t;

    abmio_pkg::item_t             item;
    abmio_pkg::mem_req_t          mem_req;
    logic                         accept;
    logic                         clearing;
    logic [abmio_pkg::BYTE_W-1:0] mem_rd_data;
    logic [abmio_pkg::BYTE_W-1:0] io_data;
    logic                         rd_in_store;
    logic                         rd_in_mirror;
    src_t                         src_next;
    src_t                         src_reg;
    logic                         s1_valid_reg;
    logic [abmio_pkg::BYTE_W-1:0] read_data_reg;
    logic [abmio_pkg::BYTE_W-1:0] read_data_next;
    logic                         done_reg;

    assign item.op      = abmio_pkg::op_t'(op);
    assign item.address = address;
    assign item.port    = port;
    assign item.data    = data;
    assign item.button  = button;
    assign item.pressed = pressed;

    assign accept = start && !clearing;
    assign busy   = clearing;

    assign rd_in_store  = (address[15:14] == 2'b00);
    assign rd_in_mirror = (address[15:13] == 3'b010);

    always_comb
    begin
        mem_req.rd_en   = accept && item.op == abmio_pkg::OP_MEM_READ;
        mem_req.rd_addr = rd_in_store ? address[abmio_pkg::MEM_ADDR_W-1:0]
                                      : {1'b1, address[12:0]};
        mem_req.wr_addr = address[abmio_pkg::MEM_ADDR_W-1:0];
        mem_req.wr_data = data;
        mem_req.wr_en   = 1'b0;
        if (accept && item.op == abmio_pkg::OP_MEM_WRITE && address[15:13] == 3'b001)
        begin
            mem_req.wr_en = 1'b1;
        end
        if (accept && item.op == abmio_pkg::OP_ROM_LOAD && rd_in_store)
        begin
            mem_req.wr_en = 1'b1;
        end
    end

    always_comb
    begin
        case (item.op)
            abmio_pkg::OP_MEM_READ: src_next = (rd_in_store || rd_in_mirror) ? SRC_MEM : SRC_ZERO;
            abmio_pkg::OP_IO_IN:    src_next = SRC_IO;
            default:                src_next = SRC_ZERO;
        endcase
    end

    always_comb
    begin
        case (src_reg)
            SRC_MEM: read_data_next = mem_rd_data;
            SRC_IO:  read_data_next = io_data;
            default: read_data_next = '0;
        endcase
    end

    abmio_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_data  (mem_rd_data),
        .clearing (clearing)
    );

    abmio_io u_io (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .io_data   (io_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            src_reg      <= SRC_ZERO;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
            if (accept)
            begin
                src_reg <= src_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign read_data = read_data_reg;
    assign done      = done_reg;

`ifndef ASSERT_OFF
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted item gave no result");

    a_refused_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && busy) |-> ##2 !done)
        else $error("result from an item taken while busy");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op != abmio_pkg::OP_MEM_READ && op != abmio_pkg::OP_IO_IN)
        |-> ##2 (read_data == '0))
        else $error("non-read item gave a non-zero result");

    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(busy))
        else $error("store sweep restarted without reset");
`endif

endmodule

`default_nettype wire

[sv/abmio_mem.sv]
// 16 KiB board store with one write and one registered read port per cycle.
// Runs a zeroing sweep after reset. Depends on abmio_pkg.
`default_nettype none

module abmio_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire abmio_pkg::mem_req_t          req,
    output logic [abmio_pkg::BYTE_W-1:0]      rd_data,
    output logic                              clearing
);

    localparam int DEPTH = 1 << abmio_pkg::MEM_ADDR_W;

    logic [abmio_pkg::BYTE_W-1:0]     mem [DEPTH];
    logic [abmio_pkg::BYTE_W-1:0]     rd_data_reg;
    logic [abmio_pkg::MEM_ADDR_W-1:0] clear_cnt_reg;
    logic [abmio_pkg::MEM_ADDR_W-1:0] clear_cnt_next;
    logic                             clearing_reg;
    logic                             clearing_next;

    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        clearing_next  = clearing_reg;
        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (&clear_cnt_reg)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            clearing_reg  <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_cnt_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

[sv/abmio_io.sv]
// I/O ports: switch registers, button latch and the byte-window shift pair.
// Registers the input port byte of each item. Depends on abmio_pkg.
`default_nettype none

module abmio_io (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [abmio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                            accept,
    input  wire abmio_pkg::item_t                item,
    output logic [abmio_pkg::BYTE_W-1:0]         io_data
);

    logic [abmio_pkg::BYTE_W-1:0] port0_sw_reg;
    logic [abmio_pkg::BYTE_W-1:0] port2_sw_reg;
    logic [abmio_pkg::BYTE_W-1:0] shift_low_reg;
    logic [abmio_pkg::BYTE_W-1:0] shift_low_next;
    logic [abmio_pkg::BYTE_W-1:0] shift_high_reg;
    logic [abmio_pkg::BYTE_W-1:0] shift_high_next;
    logic [2:0]                   shift_amount_reg;
    logic [2:0]                   shift_amount_next;
    logic [abmio_pkg::BYTE_W-1:0] button_latch_reg;
    logic [abmio_pkg::BYTE_W-1:0] button_latch_next;
    logic [abmio_pkg::BYTE_W-1:0] io_data_reg;
    logic [abmio_pkg::BYTE_W-1:0] io_data_next;
    logic [15:0]                  pair_shifted;
    logic [abmio_pkg::BYTE_W-1:0] mask;

    assign pair_shifted = {shift_high_reg, shift_low_reg} << shift_amount_reg;
    assign mask         = abmio_pkg::button_mask(item.button);

    always_comb
    begin
        case (item.port)
            abmio_pkg::PORT_SWITCHES0:  io_data_next = port0_sw_reg;
            abmio_pkg::PORT_BUTTONS:    io_data_next = button_latch_reg;
            abmio_pkg::PORT_SWITCHES2:  io_data_next = port2_sw_reg;
            abmio_pkg::PORT_SHIFT_READ: io_data_next = pair_shifted[15:8];
            default:                    io_data_next = '0;
        endcase
    end

    always_comb
    begin
        shift_low_next    = shift_low_reg;
        shift_high_next   = shift_high_reg;
        shift_amount_next = shift_amount_reg;
        button_latch_next = button_latch_reg;
        if (accept && item.op == abmio_pkg::OP_IO_OUT)
        begin
            if (item.port == abmio_pkg::PORT_SHIFT_AMOUNT)
            begin
                shift_amount_next = item.data[2:0];
            end
            else if (item.port == abmio_pkg::PORT_SHIFT_DATA)
            begin
                shift_low_next  = shift_high_reg;
                shift_high_next = item.data;
            end
        end
        if (accept && item.op == abmio_pkg::OP_BUTTON)
        begin
            if (item.pressed)
            begin
                button_latch_next = button_latch_reg | mask;
            end
            else
            begin
                button_latch_next = button_latch_reg & ~mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port0_sw_reg     <= '0;
            port2_sw_reg     <= '0;
            shift_low_reg    <= '0;
            shift_high_reg   <= '0;
            shift_amount_reg <= '0;
            button_latch_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == abmio_pkg::CFG_PORT0_SWITCHES)
            begin
                port0_sw_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == abmio_pkg::CFG_PORT2_SWITCHES)
            begin
                port2_sw_reg <= cfg_data;
            end
            shift_low_reg    <= shift_low_next;
            shift_high_reg   <= shift_high_next;
            shift_amount_reg <= shift_amount_next;
            button_latch_reg <= button_latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            io_data_reg <= io_data_next;
        end
    end

    assign io_data = io_data_reg;

endmodule

`default_nettype wire

[verif/abmio_checker.sv]
// Checker for the arcade board memory and I/O block: watches the command, result and
// switch write channels, predicts every read byte and compares it. Depends on abmio_pkg.
`timescale 1ns / 1ps

module abmio_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [2:0]                      op,
    input  wire logic [abmio_pkg::ADDR_W-1:0]    address,
    input  wire logic [abmio_pkg::PORT_W-1:0]    port,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    data,
    input  wire logic [abmio_pkg::BUTTON_W-1:0]  button,
    input  wire logic                            pressed,
    input  wire logic                            done,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    read_data,
    input  wire logic                            cfg_write,
    input  wire logic [abmio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abmio_pkg::BYTE_W-1:0]    cfg_data,
    output logic [31:0]                          failures,
    output logic [31:0]                          outstanding,
    output logic [31:0]                          compared
);

    localparam logic [abmio_pkg::ADDR_W-1:0] RAM_BASE    = 16'h2000;
    localparam logic [abmio_pkg::ADDR_W-1:0] MIRROR_BASE = 16'h4000;
    localparam logic [abmio_pkg::ADDR_W-1:0] MIRROR_END  = 16'h6000;
    localparam int                           STORE_BYTES = 1 << abmio_pkg::MEM_ADDR_W;
    localparam int                           REPORT_MAX  = 10;

    logic [abmio_pkg::BYTE_W-1:0]  board_bytes [0:STORE_BYTES-1];
    logic [abmio_pkg::BYTE_W-1:0]  shift_lo;
    logic [abmio_pkg::BYTE_W-1:0]  shift_hi;
    logic [2:0]                    window_offset;
    logic [abmio_pkg::BYTE_W-1:0]  buttons_held;
    logic [abmio_pkg::BYTE_W-1:0]  switches0;
    logic [abmio_pkg::BYTE_W-1:0]  switches2;
    logic [abmio_pkg::BYTE_W-1:0]  expected_read_q [$];

    function automatic logic [abmio_pkg::BYTE_W-1:0] predict_bus_access(
        input logic [2:0]                     a_op,
        input logic [abmio_pkg::ADDR_W-1:0]   a_addr,
        input logic [abmio_pkg::PORT_W-1:0]   a_port,
        input logic [abmio_pkg::BYTE_W-1:0]   a_data,
        input logic [abmio_pkg::BUTTON_W-1:0] a_btn,
        input logic                           a_pressed
    );
        logic [abmio_pkg::BYTE_W-1:0] result;
        logic [abmio_pkg::BYTE_W-1:0] mask;
        logic [15:0]                  pair;
        logic [15:0]                  window;
        logic [abmio_pkg::ADDR_W-1:0] mirrored;
        result = '0;
        case (a_op)
            abmio_pkg::OP_MEM_READ:
            begin
                mirrored = a_addr - RAM_BASE;
                if (a_addr >= MIRROR_END)
                    result = '0;
                else if (a_addr >= MIRROR_BASE)
                    result = board_bytes[mirrored[abmio_pkg::MEM_ADDR_W-1:0]];
                else
                    result = board_bytes[a_addr[abmio_pkg::MEM_ADDR_W-1:0]];
            end
            abmio_pkg::OP_MEM_WRITE:
            begin
                if (a_addr >= RAM_BASE && a_addr < MIRROR_BASE)
                    board_bytes[a_addr[abmio_pkg::MEM_ADDR_W-1:0]] = a_data;
            end
            abmio_pkg::OP_IO_IN:
            begin
                case (a_port)
                    abmio_pkg::PORT_SWITCHES0:  result = switches0;
                    abmio_pkg::PORT_BUTTONS:    result = buttons_held;
                    abmio_pkg::PORT_SWITCHES2:  result = switches2;
                    abmio_pkg::PORT_SHIFT_READ:
                    begin
                        pair   = {shift_hi, shift_lo};
                        window = pair >> (4'd8 - {1'b0, window_offset});
                        result = window[abmio_pkg::BYTE_W-1:0];
                    end
                    default:                    result = '0;
                endcase
            end
            abmio_pkg::OP_IO_OUT:
            begin
                if (a_port == abmio_pkg::PORT_SHIFT_AMOUNT)
                    window_offset = a_data[2:0];
                else if (a_port == abmio_pkg::PORT_SHIFT_DATA)
                begin
                    shift_lo = shift_hi;
                    shift_hi = a_data;
                end
            end
            abmio_pkg::OP_BUTTON:
            begin
                case (a_btn)
                    abmio_pkg::BTN_COIN:       mask = 8'h01;
                    abmio_pkg::BTN_TWO_PLAYER: mask = 8'h02;
                    abmio_pkg::BTN_ONE_PLAYER: mask = 8'h04;
                    abmio_pkg::BTN_FIRE:       mask = 8'h10;
                    abmio_pkg::BTN_LEFT:       mask = 8'h20;
                    abmio_pkg::BTN_RIGHT:      mask = 8'h40;
                    default:                   mask = 8'h00;
                endcase
                if (a_pressed)
                    buttons_held = buttons_held | mask;
                else
                    buttons_held = buttons_held & ~mask;
            end
            abmio_pkg::OP_ROM_LOAD:
            begin
                if (a_addr < MIRROR_BASE)
                    board_bytes[a_addr[abmio_pkg::MEM_ADDR_W-1:0]] = a_data;
            end
            default:
            begin
            end
        endcase
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [abmio_pkg::BYTE_W-1:0] wanted;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                board_bytes[i] = '0;
            shift_lo      = '0;
            shift_hi      = '0;
            window_offset = '0;
            buttons_held  = '0;
            switches0     = '0;
            switches2     = '0;
            expected_read_q.delete();
            failures      = 0;
            compared      = 0;
            outstanding   = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_read_q.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= REPORT_MAX)
                        $display("%0t: result %02h with no item outstanding", $realtime, read_data);
                end
                else
                begin
                    wanted   = expected_read_q.pop_front();
                    compared = compared + 1;
                    if (read_data !== wanted)
                    begin
                        failures = failures + 1;
                        if (failures <= REPORT_MAX)
                            $display("%0t: read_data expected %02h, actual %02h",
                                     $realtime, wanted, read_data);
                    end
                end
            end
            if (start && !busy)
                expected_read_q.push_back(predict_bus_access(op, address, port, data,
                                                             button, pressed));
            if (cfg_write)
            begin
                if (cfg_index == abmio_pkg::CFG_PORT0_SWITCHES)
                    switches0 = cfg_data;
                else if (cfg_index == abmio_pkg::CFG_PORT2_SWITCHES)
                    switches2 = cfg_data;
            end
            outstanding = expected_read_q.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the arcade board memory and I/O testbench: clock, reset, bus items, switch
// writes and the verdict. Depends on abmio_pkg, abmio_checker and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int         ADDR_W       = abmio_pkg::ADDR_W;
    localparam int         PORT_W       = abmio_pkg::PORT_W;
    localparam int         BYTE_W       = abmio_pkg::BYTE_W;
    localparam int         BUTTON_W     = abmio_pkg::BUTTON_W;
    localparam int         CFG_IDX_W    = abmio_pkg::CFG_IDX_W;
    localparam logic [2:0] OP_SPARE6    = 3'd6;
    localparam logic [2:0] OP_SPARE7    = 3'd7;
    localparam int         PHASE_ITEMS  = 450;
    localparam int         CYCLE_LIMIT  = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           op;
    logic [ADDR_W-1:0]    address;
    logic [PORT_W-1:0]    port;
    logic [BYTE_W-1:0]    data;
    logic [BUTTON_W-1:0]  button;
    logic                 pressed;
    logic [BYTE_W-1:0]    read_data;
    logic                 done;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic [31:0]          failures;
    logic [31:0]          outstanding;
    logic [31:0]          compared;

    int idle_pct;
    int issued_items;
    int switch_settings;
    int cycles;

    arcade_board_memory_and_io u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .address   (address),
        .port      (port),
        .data      (data),
        .button    (button),
        .pressed   (pressed),
        .read_data (read_data),
        .done      (done),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    abmio_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .address     (address),
        .port        (port),
        .data        (data),
        .button      (button),
        .pressed     (pressed),
        .done        (done),
        .read_data   (read_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic issue_item(
        input logic [2:0]          i_op,
        input logic [ADDR_W-1:0]   i_addr,
        input logic [PORT_W-1:0]   i_port,
        input logic [BYTE_W-1:0]   i_data,
        input logic [BUTTON_W-1:0] i_btn,
        input logic                i_pressed
    );
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        op      <= i_op;
        address <= i_addr;
        port    <= i_port;
        data    <= i_data;
        button  <= i_btn;
        pressed <= i_pressed;
        do
            @(posedge clk);
        while (busy);
        issued_items++;
    endtask

    task automatic set_switches(input logic [BYTE_W-1:0] sw0, input logic [BYTE_W-1:0] sw2);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= abmio_pkg::CFG_PORT0_SWITCHES;
        cfg_data  <= sw0;
        @(negedge clk);
        cfg_index <= abmio_pkg::CFG_PORT2_SWITCHES;
        cfg_data  <= sw2;
        @(negedge clk);
        cfg_write <= 1'b0;
        switch_settings++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] offset;
        offset = ADDR_W'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
            0:       return 16'h0000 + offset;
            1:       return 16'h2000 + offset;
            2:       return 16'h3FC0 + offset;
            3:       return 16'h4000 + offset;
            4:       return 16'h5FC0 + offset;
            default: return ADDR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_item();
        int                pick;
        logic [2:0]        r_op;
        logic [PORT_W-1:0] r_port;
        pick   = $urandom_range(0, 99);
        r_port = PORT_W'($urandom_range(0, 255));
        if (pick < 25)
            r_op = abmio_pkg::OP_MEM_READ;
        else if (pick < 45)
            r_op = abmio_pkg::OP_MEM_WRITE;
        else if (pick < 65)
            r_op = abmio_pkg::OP_IO_IN;
        else if (pick < 80)
            r_op = abmio_pkg::OP_IO_OUT;
        else if (pick < 90)
            r_op = abmio_pkg::OP_BUTTON;
        else if (pick < 97)
            r_op = abmio_pkg::OP_ROM_LOAD;
        else
            r_op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
        if (r_op == abmio_pkg::OP_IO_IN && $urandom_range(0, 9) < 8)
            r_port = PORT_W'($urandom_range(0, 4));
        else if (r_op == abmio_pkg::OP_IO_OUT && $urandom_range(0, 9) < 8)
            r_port = ($urandom_range(0, 2) == 0) ? abmio_pkg::PORT_SHIFT_AMOUNT
                                                 : abmio_pkg::PORT_SHIFT_DATA;
        issue_item(r_op, pick_address(), r_port, BYTE_W'($urandom_range(0, 255)),
                   BUTTON_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = abmio_pkg::OP_MEM_READ;
        address         = '0;
        port            = '0;
        data            = '0;
        button          = '0;
        pressed         = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        idle_pct        = 21;
        issued_items    = 0;
        switch_settings = 0;
        cycles          = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // hold until the store clearing sweep ends
        @(negedge clk);
        while (busy)
            @(negedge clk);

        set_switches(8'hA5, 8'h5A);
        issue_item(abmio_pkg::OP_MEM_WRITE, 16'h2000, 8'h00, 8'hFF, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_WRITE, 16'h3FFF, 8'h00, 8'h81, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_WRITE, 16'h1FFF, 8'h00, 8'h12, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_WRITE, 16'h4000, 8'h00, 8'h34, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'h4000, 8'h00, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'h5FFF, 8'h00, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'h6000, 8'h00, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'hFFFF, 8'hFF, 8'hFF, 3'd7, 1'b1);
        issue_item(abmio_pkg::OP_ROM_LOAD, 16'h0000, 8'h00, 8'h77, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_ROM_LOAD, 16'h4000, 8'h00, 8'h99, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_MEM_READ, 16'h1FFF, 8'h00, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_OUT, 16'h0000, abmio_pkg::PORT_SHIFT_DATA,
                   8'hAB, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_OUT, 16'h0000, abmio_pkg::PORT_SHIFT_DATA,
                   8'hCD, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, abmio_pkg::PORT_SHIFT_READ,
                   8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_OUT, 16'h0000, abmio_pkg::PORT_SHIFT_AMOUNT,
                   8'hFF, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, abmio_pkg::PORT_SHIFT_READ,
                   8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_OUT, 16'h0000, 8'hFF, 8'h55, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, abmio_pkg::PORT_SWITCHES0,
                   8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, abmio_pkg::PORT_SWITCHES2,
                   8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, 8'hFF, 8'h00, 3'd0, 1'b0);
        issue_item(abmio_pkg::OP_BUTTON, 16'h0000, 8'h00, 8'h00, abmio_pkg::BTN_RIGHT, 1'b1);
        issue_item(abmio_pkg::OP_BUTTON, 16'h0000, 8'h00, 8'h00, 3'd7, 1'b1);
        issue_item(abmio_pkg::OP_IO_IN, 16'h0000, abmio_pkg::PORT_BUTTONS,
                   8'h00, 3'd0, 1'b0);
        issue_item(OP_SPARE7, 16'hFFFF, 8'hFF, 8'hFF, 3'd7, 1'b1);
        issue_item(OP_SPARE6, 16'h2000, abmio_pkg::PORT_BUTTONS, 8'h5A, 3'd0, 1'b0);
        drain_results();

        set_switches(8'h00, 8'hFF);
        repeat (PHASE_ITEMS) random_item();
        drain_results();

        set_switches(8'hFF, 8'h00);
        idle_pct = 0;
        repeat (PHASE_ITEMS) random_item();
        drain_results();

        set_switches(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        idle_pct = 21;
        repeat (PHASE_ITEMS) random_item();
        drain_results();

        set_switches(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        repeat (PHASE_ITEMS) random_item();
        drain_results();

        $display("Run covered %0d bus items under %0d switch settings; %0d results compared.",
                 issued_items, switch_settings, compared);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[arcade_board_memory_and_io.f]
sv/abmio_pkg.sv
sv/abmio_mem.sv
sv/abmio_io.sv
sv/arcade_board_memory_and_io.sv
verif/abmio_checker.sv
verif/testbench.sv
